/* hw/rtl/bls_pkg.sv */
`default_nettype none
package bls_pkg;

  // field widths fixed by the interface
  localparam int unsigned COORD_BITS  = 13;
  localparam int unsigned PIXEL_BITS  = 24;
  localparam int unsigned LEN_BITS    = 20;
  localparam int unsigned SCALE_BITS  = 7;
  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned IMAGE_BITS  = 13;

  // scaled endpoint: 13x8 signed product plus a 16 bit offset
  localparam int unsigned SCALED_BITS = 21;
  // error term lives in [-2*major, 2*minor), major below 2^20
  localparam int unsigned ERR_BITS    = 23;

  // configuration port
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_SCALE        = 3'd0;
  localparam cfg_index_t REG_ORIGIN_X     = 3'd1;
  localparam cfg_index_t REG_ORIGIN_Y     = 3'd2;
  localparam cfg_index_t REG_IMAGE_WIDTH  = 3'd3;
  localparam cfg_index_t REG_IMAGE_HEIGHT = 3'd4;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 7'd1;
  localparam logic [IMAGE_BITS-1:0] IMAGE_RESET = 13'd1024;

  localparam logic ACTION_LOAD    = 1'b0;
  localparam logic ACTION_ADVANCE = 1'b1;

endpackage
`default_nettype wire

/* hw/rtl/bls_if.sv */
`default_nettype none
interface bls_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      action;
  logic signed [bls_pkg::COORD_BITS-1:0]     start_x;
  logic signed [bls_pkg::COORD_BITS-1:0]     start_y;
  logic signed [bls_pkg::COORD_BITS-1:0]     end_x;
  logic signed [bls_pkg::COORD_BITS-1:0]     end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bls_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [bls_pkg::PIXEL_BITS-1:0]     pixel_x;
  logic signed [bls_pkg::PIXEL_BITS-1:0]     pixel_y;
  logic                                      visible;
  logic [bls_pkg::LEN_BITS-1:0]              step_index;
  logic [bls_pkg::LEN_BITS-1:0]              line_length;
  logic                                      last;

  modport source (output valid, pixel_x, pixel_y, visible, step_index, line_length, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, visible, step_index, line_length, last,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/bresenham_line_stepper.sv */
`default_nettype none
// Bresenham line stepper. A load word (action 0) takes two endpoints, scales
// them by the scale register, adds the offsets and sets up the walk; it gives
// no output word. Each advance word (action 1) then gives one pixel, starting
// at the start point and stopping one pixel short of the end point, with a
// visibility flag, a one-based step index, the line length and a last mark.
// A zero-length line, or an advance with no line in progress, gives nothing.
// The walk is a single add-compare of the error term per clock, and one
// output register separates the two channels, so a word can be taken every
// cycle while the output side keeps up. Positions
// wrap at POSITION_BITS; write the registers only while the block is idle.
module bresenham_line_stepper #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire [bls_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire [bls_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  bls_in_if.sink                                line_in,
  bls_out_if.source                             pixel_out
);

  localparam int unsigned P  = POSITION_BITS;
  localparam int unsigned SB = bls_pkg::SCALED_BITS;
  localparam int unsigned EB = bls_pkg::ERR_BITS;
  localparam int unsigned LB = bls_pkg::LEN_BITS;

  // configuration
  logic [bls_pkg::SCALE_BITS-1:0]         scale;
  logic signed [bls_pkg::OFFSET_BITS-1:0] origin_x;
  logic signed [bls_pkg::OFFSET_BITS-1:0] origin_y;
  logic [bls_pkg::IMAGE_BITS-1:0]         image_width;
  logic [bls_pkg::IMAGE_BITS-1:0]         image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= bls_pkg::SCALE_RESET;
      origin_x     <= '0;
      origin_y     <= '0;
      image_width  <= bls_pkg::IMAGE_RESET;
      image_height <= bls_pkg::IMAGE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bls_pkg::REG_SCALE:        scale        <= cfg_data[bls_pkg::SCALE_BITS-1:0];
        bls_pkg::REG_ORIGIN_X:     origin_x     <= cfg_data;
        bls_pkg::REG_ORIGIN_Y:     origin_y     <= cfg_data;
        bls_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[bls_pkg::IMAGE_BITS-1:0];
        bls_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[bls_pkg::IMAGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // walk state
  logic signed [P-1:0]  pos_x;
  logic signed [P-1:0]  pos_y;
  logic signed [EB-1:0] error_term;
  logic [LB-1:0]        major_len;
  logic [LB-1:0]        minor_len;
  logic                 dir_x_negative;
  logic                 dir_y_negative;
  logic                 x_is_major;
  logic [LB-1:0]        step_count;
  logic                 line_active;

  // output register
  logic                 out_valid;
  logic signed [bls_pkg::PIXEL_BITS-1:0] out_x;
  logic signed [bls_pkg::PIXEL_BITS-1:0] out_y;
  logic                 out_visible;
  logic [LB-1:0]        out_step;
  logic [LB-1:0]        out_length;
  logic                 out_last;

  logic accept;
  logic is_load;
  logic is_step;

  assign line_in.ready = !out_valid || pixel_out.ready;
  assign accept  = line_in.valid && line_in.ready;
  assign is_load = accept && (line_in.action == bls_pkg::ACTION_LOAD);
  assign is_step = accept && (line_in.action == bls_pkg::ACTION_ADVANCE) && line_active;

  // load setup: deltas come from the endpoint difference, the offset cancels
  logic signed [7:0]    scale_s;
  logic signed [SB-1:0] x0;
  logic signed [SB-1:0] y0;
  logic signed [13:0]   diff_x;
  logic signed [13:0]   diff_y;
  logic signed [SB-1:0] dx;
  logic signed [SB-1:0] dy;
  logic signed [SB-1:0] neg_dx;
  logic signed [SB-1:0] neg_dy;
  logic [LB-1:0]        abs_dx;
  logic [LB-1:0]        abs_dy;
  logic                 load_x_major;
  logic [LB-1:0]        load_major;
  logic [LB-1:0]        load_minor;
  logic signed [EB-1:0] load_error;

  always_comb begin
    scale_s = $signed({1'b0, scale});
    x0 = SB'(line_in.start_x * scale_s) + SB'(origin_x);
    y0 = SB'(line_in.start_y * scale_s) + SB'(origin_y);
    diff_x = 14'(line_in.end_x) - 14'(line_in.start_x);
    diff_y = 14'(line_in.end_y) - 14'(line_in.start_y);
    dx = SB'(diff_x * scale_s);
    dy = SB'(diff_y * scale_s);
    neg_dx = -dx;
    neg_dy = -dy;
    abs_dx = dx[SB-1] ? neg_dx[LB-1:0] : dx[LB-1:0];
    abs_dy = dy[SB-1] ? neg_dy[LB-1:0] : dy[LB-1:0];
    // a tie makes y the major axis
    load_x_major = abs_dx > abs_dy;
    load_major = load_x_major ? abs_dx : abs_dy;
    load_minor = load_x_major ? abs_dy : abs_dx;
    load_error = $signed(EB'({load_minor, 1'b0})) - $signed(EB'(load_major));
  end

  // one step of the walk
  logic signed [P-1:0]  step_x;
  logic signed [P-1:0]  step_y;
  logic signed [P-1:0]  pos_x_next;
  logic signed [P-1:0]  pos_y_next;
  logic signed [EB-1:0] error_next;
  logic [LB-1:0]        step_count_next;
  logic                 step_last;
  logic                 step_visible;
  logic                 minor_move;

  always_comb begin
    step_x = dir_x_negative ? '1 : P'(1);
    step_y = dir_y_negative ? '1 : P'(1);
    minor_move = !error_term[EB-1];
    step_count_next = step_count + LB'(1);
    step_last = step_count_next >= major_len;
    step_visible = !pos_x[P-1] && (pos_x < $signed(P'(image_width))) &&
                   !pos_y[P-1] && (pos_y < $signed(P'(image_height)));
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    if (x_is_major) begin
      pos_x_next = pos_x + step_x;
      if (minor_move) pos_y_next = pos_y + step_y;
    end else begin
      pos_y_next = pos_y + step_y;
      if (minor_move) pos_x_next = pos_x + step_x;
    end
    if (minor_move) begin
      error_next = error_term + $signed(EB'({minor_len, 1'b0}))
                   - $signed(EB'({major_len, 1'b0}));
    end else begin
      error_next = error_term + $signed(EB'({minor_len, 1'b0}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (is_load) begin
      line_active <= load_major != '0;
    end else if (is_step && step_last) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_load) begin
      pos_x          <= P'(x0);
      pos_y          <= P'(y0);
      error_term     <= load_error;
      major_len      <= load_major;
      minor_len      <= load_minor;
      dir_x_negative <= dx[SB-1];
      dir_y_negative <= dy[SB-1];
      x_is_major     <= load_x_major;
      step_count     <= '0;
    end else if (is_step) begin
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      error_term <= error_next;
      step_count <= step_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_step) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_step) begin
      out_x       <= bls_pkg::PIXEL_BITS'(pos_x);
      out_y       <= bls_pkg::PIXEL_BITS'(pos_y);
      out_visible <= step_visible;
      out_step    <= step_count_next;
      out_length  <= major_len;
      out_last    <= step_last;
    end
  end

  assign pixel_out.valid       = out_valid;
  assign pixel_out.pixel_x     = out_x;
  assign pixel_out.pixel_y     = out_y;
  assign pixel_out.visible     = out_visible;
  assign pixel_out.step_index  = out_step;
  assign pixel_out.line_length = out_length;
  assign pixel_out.last        = out_last;

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none
module tb;

  localparam int STUCK_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int SQUEEZE_CYCLES = 200;
  localparam int WORD_TARGET    = 950;

  typedef struct {
    logic                                   action;
    logic signed [bls_pkg::COORD_BITS-1:0]  start_x;
    logic signed [bls_pkg::COORD_BITS-1:0]  start_y;
    logic signed [bls_pkg::COORD_BITS-1:0]  end_x;
    logic signed [bls_pkg::COORD_BITS-1:0]  end_y;
  } line_word_t;

  typedef struct {
    logic signed [bls_pkg::PIXEL_BITS-1:0]  px;
    logic signed [bls_pkg::PIXEL_BITS-1:0]  py;
    logic                                   vis;
    logic [bls_pkg::LEN_BITS-1:0]           idx;
    logic [bls_pkg::LEN_BITS-1:0]           len;
    logic                                   fin;
  } pixel_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  bls_pkg::cfg_index_t cfg_index;
  logic [bls_pkg::CFG_DATA_BITS-1:0] cfg_data;

  bls_in_if  line_in_bus ();
  bls_out_if pixel_out_bus ();

  bresenham_line_stepper #(
    .POSITION_BITS(bls_pkg::PIXEL_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .line_in   (line_in_bus),
    .pixel_out (pixel_out_bus)
  );

  // register copies used for prediction
  logic [bls_pkg::SCALE_BITS-1:0]         cfg_scale  = bls_pkg::SCALE_RESET;
  logic signed [bls_pkg::OFFSET_BITS-1:0] cfg_off_x  = '0;
  logic signed [bls_pkg::OFFSET_BITS-1:0] cfg_off_y  = '0;
  logic [bls_pkg::IMAGE_BITS-1:0]         cfg_width  = bls_pkg::IMAGE_RESET;
  logic [bls_pkg::IMAGE_BITS-1:0]         cfg_height = bls_pkg::IMAGE_RESET;

  // walk state
  logic signed [bls_pkg::PIXEL_BITS-1:0] walk_x = '0;
  logic signed [bls_pkg::PIXEL_BITS-1:0] walk_y = '0;
  longint                                err_acc = 0;
  logic [bls_pkg::LEN_BITS-1:0]          span_x = '0;
  logic [bls_pkg::LEN_BITS-1:0]          span_y = '0;
  logic [bls_pkg::LEN_BITS-1:0]          steps_done = '0;
  bit back_x, back_y, x_leads, walking;

  line_word_t  line_words [$];
  pixel_word_t pixels_due [$];

  line_word_t  next_word;
  line_word_t  took_word;
  pixel_word_t got_pixel;

  logic in_took = 1'b0;
  bit   in_idle_on = 1'b1;
  bit   out_idle_on = 1'b1;
  bit   squeeze_req = 1'b0;
  bit   squeeze_done = 1'b0;
  int   feed_gap = 0;
  int   stall_left = 0;
  int   squeeze_left = 0;
  int   stuck_cycles = 0;

  int fail_count = 0;
  int shown = 0;
  int counted_words = 0;
  int words_taken = 0;
  int loads_taken = 0;
  int pixels_seen = 0;
  int pixels_visible = 0;
  int lines_finished = 0;
  int settings_used = 0;

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int clamp13(int v);
    if (v < -4096) return -4096;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // unscaled coordinate that lands near the image after scale and offset
  function automatic int aim(int extent, int off, int scl);
    int target = int'($urandom_range(extent + 16)) - 8;
    return clamp13((target - off) / scl);
  endfunction

  task automatic walk_line(input line_word_t w);
    longint x0, y0, x1, y1, dx, dy, lead, lag, px, py;
    logic signed [bls_pkg::PIXEL_BITS-1:0] unit_x, unit_y;
    pixel_word_t due;
    if (w.action == bls_pkg::ACTION_LOAD) begin
      x0 = longint'(w.start_x) * longint'(cfg_scale) + longint'(cfg_off_x);
      y0 = longint'(w.start_y) * longint'(cfg_scale) + longint'(cfg_off_y);
      x1 = longint'(w.end_x) * longint'(cfg_scale) + longint'(cfg_off_x);
      y1 = longint'(w.end_y) * longint'(cfg_scale) + longint'(cfg_off_y);
      dx = x1 - x0;
      dy = y1 - y0;
      back_x = dx < 0;
      back_y = dy < 0;
      span_x = bls_pkg::LEN_BITS'(back_x ? -dx : dx);
      span_y = bls_pkg::LEN_BITS'(back_y ? -dy : dy);
      x_leads = span_x > span_y;
      lead = x_leads ? span_x : span_y;
      lag = x_leads ? span_y : span_x;
      err_acc = 2 * lag - lead;
      walk_x = x0[bls_pkg::PIXEL_BITS-1:0];
      walk_y = y0[bls_pkg::PIXEL_BITS-1:0];
      steps_done = '0;
      walking = lead != 0;
    end else if (walking) begin
      lead = x_leads ? span_x : span_y;
      lag = x_leads ? span_y : span_x;
      unit_x = back_x ? '1 : bls_pkg::PIXEL_BITS'(1);
      unit_y = back_y ? '1 : bls_pkg::PIXEL_BITS'(1);
      steps_done = steps_done + 1'b1;
      px = walk_x;
      py = walk_y;
      due.px = walk_x;
      due.py = walk_y;
      due.vis = px >= 0 && px < longint'(cfg_width) && py >= 0 && py < longint'(cfg_height);
      due.idx = steps_done;
      due.len = lead[bls_pkg::LEN_BITS-1:0];
      due.fin = steps_done >= lead;
      if (x_leads) walk_x = walk_x + unit_x;
      else walk_y = walk_y + unit_y;
      if (err_acc < 0) begin
        err_acc += 2 * lag;
      end else begin
        err_acc += 2 * lag - 2 * lead;
        if (x_leads) walk_y = walk_y + unit_y;
        else walk_x = walk_x + unit_x;
      end
      if (due.fin) walking = 1'b0;
      pixels_due.push_back(due);
    end
  endtask

  task automatic check_pixel(input pixel_word_t got);
    pixel_word_t want;
    bit bad;
    if (pixels_due.size() == 0) begin
      fail_count++;
      if (shown++ < 60)
        $display("%0t: pixel (%0d,%0d) step %0d with nothing expected",
                 $time, got.px, got.py, got.idx);
      return;
    end
    want = pixels_due.pop_front();
    bad = 1'b0;
    if (got.px !== want.px) begin
      bad = 1'b1;
      if (shown++ < 60)
        $display("%0t: pixel_x expected %0d got %0d", $time, want.px, got.px);
    end
    if (got.py !== want.py) begin
      bad = 1'b1;
      if (shown++ < 60)
        $display("%0t: pixel_y expected %0d got %0d", $time, want.py, got.py);
    end
    if (got.vis !== want.vis) begin
      bad = 1'b1;
      if (shown++ < 60)
        $display("%0t: visible expected %0b got %0b", $time, want.vis, got.vis);
    end
    if (got.idx !== want.idx) begin
      bad = 1'b1;
      if (shown++ < 60)
        $display("%0t: step_index expected %0d got %0d", $time, want.idx, got.idx);
    end
    if (got.len !== want.len) begin
      bad = 1'b1;
      if (shown++ < 60)
        $display("%0t: line_length expected %0d got %0d", $time, want.len, got.len);
    end
    if (got.fin !== want.fin) begin
      bad = 1'b1;
      if (shown++ < 60)
        $display("%0t: last expected %0b got %0b", $time, want.fin, got.fin);
    end
    if (bad) fail_count++;
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    in_took <= !rst && line_in_bus.valid && line_in_bus.ready;
    if (!rst && line_in_bus.valid && line_in_bus.ready) begin
      took_word.action  = line_in_bus.action;
      took_word.start_x = line_in_bus.start_x;
      took_word.start_y = line_in_bus.start_y;
      took_word.end_x   = line_in_bus.end_x;
      took_word.end_y   = line_in_bus.end_y;
      words_taken++;
      if (took_word.action == bls_pkg::ACTION_LOAD) loads_taken++;
      walk_line(took_word);
    end
    if (!rst && pixel_out_bus.valid && pixel_out_bus.ready) begin
      got_pixel.px  = pixel_out_bus.pixel_x;
      got_pixel.py  = pixel_out_bus.pixel_y;
      got_pixel.vis = pixel_out_bus.visible;
      got_pixel.idx = pixel_out_bus.step_index;
      got_pixel.len = pixel_out_bus.line_length;
      got_pixel.fin = pixel_out_bus.last;
      pixels_seen++;
      if (got_pixel.vis === 1'b1) pixels_visible++;
      if (got_pixel.fin === 1'b1) lines_finished++;
      check_pixel(got_pixel);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      line_in_bus.valid <= 1'b0;
    end else if (!line_in_bus.valid || in_took) begin
      if (feed_gap > 0) begin
        feed_gap--;
        line_in_bus.valid <= 1'b0;
      end else if (line_words.size() != 0) begin
        next_word = line_words.pop_front();
        line_in_bus.valid   <= 1'b1;
        line_in_bus.action  <= next_word.action;
        line_in_bus.start_x <= next_word.start_x;
        line_in_bus.start_y <= next_word.start_y;
        line_in_bus.end_x   <= next_word.end_x;
        line_in_bus.end_y   <= next_word.end_y;
        feed_gap = in_idle_on ? pick_gap() : 0;
      end else begin
        line_in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pixel_out_bus.ready <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      // one long hold so the block backs up into its input
      squeeze_done = 1'b1;
      squeeze_left = SQUEEZE_CYCLES - 1;
      pixel_out_bus.ready <= 1'b0;
    end else if (squeeze_left > 0) begin
      squeeze_left--;
      pixel_out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pixel_out_bus.ready <= 1'b0;
    end else begin
      pixel_out_bus.ready <= 1'b1;
      stall_left = out_idle_on ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (line_in_bus.valid && line_in_bus.ready) ||
        (pixel_out_bus.valid && pixel_out_bus.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
      $display("[bresenham_line_stepper] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic push_load(input int sx, input int sy, input int ex, input int ey);
    line_word_t w;
    w.action  = bls_pkg::ACTION_LOAD;
    w.start_x = sx[bls_pkg::COORD_BITS-1:0];
    w.start_y = sy[bls_pkg::COORD_BITS-1:0];
    w.end_x   = ex[bls_pkg::COORD_BITS-1:0];
    w.end_y   = ey[bls_pkg::COORD_BITS-1:0];
    line_words.push_back(w);
    counted_words++;
  endtask

  task automatic push_steps(input int n);
    line_word_t w;
    repeat (n) begin
      // coordinates are don't-care on an advance, so toggle them anyway
      w.action  = bls_pkg::ACTION_ADVANCE;
      w.start_x = bls_pkg::COORD_BITS'($urandom);
      w.start_y = bls_pkg::COORD_BITS'($urandom);
      w.end_x   = bls_pkg::COORD_BITS'($urandom);
      w.end_y   = bls_pkg::COORD_BITS'($urandom);
      line_words.push_back(w);
      counted_words++;
    end
  endtask

  task automatic set_reg(input bls_pkg::cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[bls_pkg::CFG_DATA_BITS-1:0];
    case (idx)
      bls_pkg::REG_SCALE:        cfg_scale  = value[bls_pkg::SCALE_BITS-1:0];
      bls_pkg::REG_ORIGIN_X:     cfg_off_x  = value[bls_pkg::OFFSET_BITS-1:0];
      bls_pkg::REG_ORIGIN_Y:     cfg_off_y  = value[bls_pkg::OFFSET_BITS-1:0];
      bls_pkg::REG_IMAGE_WIDTH:  cfg_width  = value[bls_pkg::IMAGE_BITS-1:0];
      bls_pkg::REG_IMAGE_HEIGHT: cfg_height = value[bls_pkg::IMAGE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input int scl, input int ox, input int oy,
                             input int wd, input int ht);
    set_reg(bls_pkg::REG_SCALE, scl);
    set_reg(bls_pkg::REG_ORIGIN_X, ox);
    set_reg(bls_pkg::REG_ORIGIN_Y, oy);
    set_reg(bls_pkg::REG_IMAGE_WIDTH, wd);
    set_reg(bls_pkg::REG_IMAGE_HEIGHT, ht);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // wait until every word is in and every pixel is out, then let the block settle
  task automatic drain();
    while (line_words.size() != 0 || line_in_bus.valid || pixels_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_random_line();
    int r, scl, sx, sy, ex, ey, reach, len, steps, adx, ady;
    r = $urandom_range(99);
    scl = cfg_scale;
    if (r < 10) begin
      sx = int'($urandom_range(8191)) - 4096;
      sy = int'($urandom_range(8191)) - 4096;
      ex = int'($urandom_range(8191)) - 4096;
      ey = int'($urandom_range(8191)) - 4096;
    end else begin
      sx = aim(cfg_width, cfg_off_x, scl);
      sy = aim(cfg_height, cfg_off_y, scl);
      reach = 1 + 40 / scl;
      if (r < 15) begin
        ex = sx;
        ey = sy;
      end else begin
        ex = clamp13(sx + int'($urandom_range(2 * reach)) - reach);
        ey = clamp13(sy + int'($urandom_range(2 * reach)) - reach);
      end
    end
    adx = ex > sx ? ex - sx : sx - ex;
    ady = ey > sy ? ey - sy : sy - ey;
    len = (adx > ady ? adx : ady) * scl;
    if (r < 10) steps = $urandom_range(5);
    else if ($urandom_range(9) < 7) steps = len + $urandom_range(2);
    else steps = $urandom_range(len);
    push_load(sx, sy, ex, ey);
    push_steps(steps);
    if ($urandom_range(19) == 0) push_steps(1);
  endtask

  initial begin
    int r, scl, ox, oy, wd, ht;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = bls_pkg::REG_SCALE;
    cfg_data = '0;
    line_in_bus.valid = 1'b0;
    line_in_bus.action = bls_pkg::ACTION_LOAD;
    line_in_bus.start_x = '0;
    line_in_bus.start_y = '0;
    line_in_bus.end_x = '0;
    line_in_bus.end_y = '0;
    pixel_out_bus.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: idle advance, extremes, replace, zero length, both majors
    push_steps(1);
    push_load(-4096, -4096, 4095, 4095);
    push_steps(1);
    push_load(4095, -4096, -4096, 4095);
    push_steps(1);
    push_load(3, 3, 3, 3);
    push_steps(1);
    push_load(0, 0, 3, 1);
    push_steps(4);
    push_load(2, 1, 0, -3);
    push_steps(4);
    drain();

    // scale zero collapses every line onto the offsets
    apply_setup(0, -32768, 32767, 1024, 1024);
    push_load(100, -50, -7, 9);
    push_steps(1);
    drain();

    // widest scale with extreme offsets and image
    apply_setup(127, 32767, -32768, 8191, 8191);
    push_load(-4096, 4095, 4095, -4096);
    push_steps(2);
    drain();

    // empty image: nothing is visible
    apply_setup(1, 0, 0, 0, 0);
    push_load(0, 0, 3, 1);
    push_steps(3);
    drain();

    // walk across the right edge of a one-row image
    apply_setup(2, 4093, 0, 4096, 1);
    push_load(0, 0, 2, 1);
    push_steps(4);
    drain();

    // back-pressure: sender never idles while the receiver holds off
    apply_setup(1, 0, 0, 1024, 1024);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    squeeze_req = 1'b1;
    push_load(0, 0, 120, 30);
    push_steps(125);
    drain();

    while (counted_words < WORD_TARGET) begin
      r = $urandom_range(99);
      if (r < 35) scl = 1;
      else if (r < 60) scl = $urandom_range(4, 2);
      else if (r < 90) scl = $urandom_range(63, 5);
      else scl = 64;
      r = $urandom_range(99);
      if (r < 50) begin
        ox = int'($urandom_range(128)) - 64;
        oy = int'($urandom_range(128)) - 64;
      end else if (r < 80) begin
        ox = int'($urandom_range(65535)) - 32768;
        oy = int'($urandom_range(65535)) - 32768;
      end else begin
        ox = 0;
        oy = 0;
      end
      r = $urandom_range(99);
      if (r < 40) begin
        wd = $urandom_range(4096, 1);
        ht = $urandom_range(4096, 1);
      end else if (r < 70) begin
        wd = $urandom_range(64, 1);
        ht = $urandom_range(64, 1);
      end else begin
        wd = 4096;
        ht = 1024;
      end
      apply_setup(scl, ox, oy, wd, ht);
      in_idle_on = $urandom_range(9) < 8;
      out_idle_on = $urandom_range(9) < 8;
      repeat ($urandom_range(20, 8))
        if (counted_words < WORD_TARGET) add_random_line();
      drain();
    end

    $display("%0d words in (%0d loads) over %0d register settings", words_taken,
             loads_taken, settings_used);
    $display("%0d pixels checked, %0d visible, %0d lines walked to the end", pixels_seen,
             pixels_visible, lines_finished);
    if (fail_count == 0) begin
      $display("[bresenham_line_stepper] OK");
    end else begin
      $display("%0d mismatching pixels", fail_count);
      $display("[bresenham_line_stepper] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
